>>> sv/lspg_pkg.sv
package lspg_pkg;

  // Status modes
  localparam logic [2:0] MODE_CONNECTING   = 3'd0;
  localparam logic [2:0] MODE_AP           = 3'd1;
  localparam logic [2:0] MODE_CONNECTED    = 3'd2;
  localparam logic [2:0] MODE_ONLINE       = 3'd3;
  localparam logic [2:0] MODE_UPDATE       = 3'd4;
  localparam logic [2:0] MODE_NOCONFIG     = 3'd5;
  localparam logic [2:0] MODE_FAILED       = 3'd6;
  localparam logic [2:0] MODE_RECONNECTING = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_FAST_PERIOD    = 3'd0;
  localparam logic [2:0] REG_SLOW_PERIOD    = 3'd1;
  localparam logic [2:0] REG_UPDATE_PERIOD  = 3'd2;
  localparam logic [2:0] REG_BURST_STEP     = 3'd3;
  localparam logic [2:0] REG_BURST_CYCLE    = 3'd4;
  localparam logic [2:0] REG_RECONNECT_ON   = 3'd5;
  localparam logic [2:0] REG_RECONNECT_OFF  = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_FAST_PERIOD   = 16'd300;
  localparam logic [15:0] RST_SLOW_PERIOD   = 16'd1000;
  localparam logic [15:0] RST_UPDATE_PERIOD = 16'd50;
  localparam logic [15:0] RST_BURST_STEP    = 16'd200;
  localparam logic [4:0]  RST_BURST_CYCLE   = 5'd20;
  localparam logic [15:0] RST_RECONNECT_ON  = 16'd1000;
  localparam logic [15:0] RST_RECONNECT_OFF = 16'd500;

  // Toggle steps per burst: two blinks and three blinks
  localparam logic [4:0] BLINKS_TWO   = 5'd4;
  localparam logic [4:0] BLINKS_THREE = 5'd6;

  localparam logic PIN_LIT  = 1'b0;
  localparam logic PIN_DARK = 1'b1;

endpackage

>>> sv/led_status_pattern_generator.sv
// Status LED pattern generator, active-low pin.
//
// Input channel: in_valid / in_stall carry one item (status_mode, now_ms).
// Output channel: out_valid / out_stall carry one item (led_level) for each
// input item, in order. led_level 0 lights the LED, 1 darkens it.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
// ready. Indexes past the last register are ignored. Write only while idle.
//
// Timing: an item is registered at accept, evaluated against the pattern
// state and moves into the output register, updating that state, once
// the output register is free. Throughput: one item per cycle while the
// receiver does not stall; the state update is a single 32-bit subtract,
// a compare and a small counter step.
//
// When the receiver stalls, the output register holds and the input register
// fills; in_stall rises only while both are full and out_stall is high.
// Reset (rst, synchronous) empties both stages, loads the register defaults,
// clears time stamp, toggle flag and burst counter, and sets the pin dark.
module led_status_pattern_generator import lspg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  status_mode,
  input  logic [31:0] now_ms,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        led_level,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] fast_period_ms;
  logic [15:0] slow_period_ms;
  logic [15:0] update_period_ms;
  logic [15:0] burst_step_ms;
  logic [4:0]  burst_cycle_steps;
  logic [15:0] reconnect_on_ms;
  logic [15:0] reconnect_off_ms;

  // pattern state, shared by all modes
  logic [31:0] last_action_ms;
  logic        toggle_flag;
  logic [4:0]  burst_step;
  logic        pin_level;

  logic [31:0] last_action_ms_next;
  logic        toggle_flag_next;
  logic [4:0]  burst_step_next;
  logic        pin_level_next;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_mode;
  logic [31:0] s1_now;

  logic        out_free;
  logic        advance;
  logic        in_take;

  logic [31:0] elapsed;
  logic [15:0] period;
  logic        due;
  logic [4:0]  blinks;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period_ms    <= RST_FAST_PERIOD;
      slow_period_ms    <= RST_SLOW_PERIOD;
      update_period_ms  <= RST_UPDATE_PERIOD;
      burst_step_ms     <= RST_BURST_STEP;
      burst_cycle_steps <= RST_BURST_CYCLE;
      reconnect_on_ms   <= RST_RECONNECT_ON;
      reconnect_off_ms  <= RST_RECONNECT_OFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FAST_PERIOD:   fast_period_ms    <= cfg_data;
        REG_SLOW_PERIOD:   slow_period_ms    <= cfg_data;
        REG_UPDATE_PERIOD: update_period_ms  <= cfg_data;
        REG_BURST_STEP:    burst_step_ms     <= cfg_data;
        REG_BURST_CYCLE:   burst_cycle_steps <= cfg_data[4:0];
        REG_RECONNECT_ON:  reconnect_on_ms   <= cfg_data;
        REG_RECONNECT_OFF: reconnect_off_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode <= status_mode;
      s1_now  <= now_ms;
    end
  end

  // Elapsed time wraps modulo 2^32; every interval test is strict.
  assign elapsed = s1_now - last_action_ms;

  always_comb begin
    unique case (s1_mode)
      MODE_AP:           period = fast_period_ms;
      MODE_CONNECTED:    period = slow_period_ms;
      MODE_UPDATE:       period = update_period_ms;
      MODE_NOCONFIG,
      MODE_FAILED:       period = burst_step_ms;
      MODE_RECONNECTING: period = toggle_flag ? reconnect_on_ms : reconnect_off_ms;
      default:           period = fast_period_ms;
    endcase
  end

  assign due    = elapsed > {16'd0, period};
  assign blinks = (s1_mode == MODE_FAILED) ? BLINKS_THREE : BLINKS_TWO;

  always_comb begin
    last_action_ms_next = last_action_ms;
    toggle_flag_next    = toggle_flag;
    burst_step_next     = burst_step;
    pin_level_next      = pin_level;
    unique case (s1_mode)
      MODE_CONNECTING: pin_level_next = PIN_LIT;
      MODE_ONLINE:     pin_level_next = PIN_DARK;
      MODE_AP,
      MODE_CONNECTED,
      MODE_UPDATE: begin
        if (due) begin
          toggle_flag_next    = !toggle_flag;
          pin_level_next      = !toggle_flag;
          last_action_ms_next = s1_now;
        end
      end
      MODE_NOCONFIG,
      MODE_FAILED: begin
        if (due) begin
          // blink phase, then dark pause, then restart
          priority if (burst_step < blinks) begin
            toggle_flag_next = !toggle_flag;
            pin_level_next   = !toggle_flag;
            burst_step_next  = burst_step + 5'd1;
          end else if (burst_step < burst_cycle_steps) begin
            pin_level_next  = PIN_DARK;
            burst_step_next = burst_step + 5'd1;
          end else begin
            burst_step_next = 5'd0;
          end
          last_action_ms_next = s1_now;
        end
      end
      default: begin
        // reconnecting: lit for the on time, dark for the off time
        if (due) begin
          toggle_flag_next    = !toggle_flag;
          pin_level_next      = toggle_flag ? PIN_DARK : PIN_LIT;
          last_action_ms_next = s1_now;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_action_ms <= 32'd0;
      toggle_flag    <= 1'b0;
      burst_step     <= 5'd0;
      pin_level      <= PIN_DARK;
    end else if (advance) begin
      last_action_ms <= last_action_ms_next;
      toggle_flag    <= toggle_flag_next;
      burst_step     <= burst_step_next;
      pin_level      <= pin_level_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_level <= pin_level_next;
    end
  end

  // The input stage is only held while it is full.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stall without a held item");

  a_connecting_lit: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_mode == MODE_CONNECTING) |=> (out_valid && led_level == PIN_LIT))
    else $error("connecting mode did not light the LED");

  a_online_dark: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_mode == MODE_ONLINE) |=> (out_valid && led_level == PIN_DARK))
    else $error("online mode did not darken the LED");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(last_action_ms) && $stable(burst_step) && $stable(toggle_flag)))
    else $error("pattern state changed without an item");

  a_result_matches_pin: assert property (@(posedge clk) disable iff (rst)
    advance |=> (led_level == pin_level))
    else $error("result differs from pin state");

endmodule
